// ----- src/ccu_pkg.sv -----
package ccu_pkg;

   // coordinate and intermediate widths
   localparam int CoordW  = 16;
   localparam int DiffW   = 17;
   localparam int SqW     = 34;
   localparam int SumW    = 35;
   localparam int DenW    = 36;
   localparam int NumW    = 52;
   localparam int QBits   = 25;
   localparam int QW      = 26;
   localparam int OutW    = 24;
   localparam int RootBits = 25;
   localparam int RadW    = 50;

   localparam logic signed [OutW-1:0] CenMax = {1'b0, {(OutW-1){1'b1}}};
   localparam logic signed [OutW-1:0] CenMin = {1'b1, {(OutW-1){1'b0}}};
   localparam logic [OutW-1:0]        RadMax = {OutW{1'b1}};

   // one quotient lane leaving the divider
   typedef struct packed {
      logic             ovf;
      logic             neg;
      logic             rem_nz;
      logic [QBits-1:0] q;
   } lane_res_type;

endpackage

// ----- src/ccu_front.sv -----
module ccu_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic signed [ccu_pkg::CoordW-1:0] p1_x,
   input  logic signed [ccu_pkg::CoordW-1:0] p1_y,
   input  logic signed [ccu_pkg::CoordW-1:0] p2_x,
   input  logic signed [ccu_pkg::CoordW-1:0] p2_y,
   input  logic signed [ccu_pkg::CoordW-1:0] p3_x,
   input  logic signed [ccu_pkg::CoordW-1:0] p3_y,
   output logic                             out_valid,
   output logic [ccu_pkg::NumW-1:0]         nx_mag,
   output logic [ccu_pkg::NumW-1:0]         ny_mag,
   output logic [ccu_pkg::DenW-1:0]         den_mag,
   output logic                             neg_x,
   output logic                             neg_y,
   output logic signed [ccu_pkg::CoordW-1:0] x1,
   output logic signed [ccu_pkg::CoordW-1:0] y1,
   output logic                             degen
);
   import ccu_pkg::*;

   logic                     v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [CoordW-1:0] x1_1_ff, y1_1_ff, x1_2_ff, y1_2_ff, x1_3_ff, y1_3_ff;
   logic signed [CoordW-1:0] x1_4_ff, y1_4_ff, x1_5_ff, y1_5_ff;
   logic signed [DiffW-1:0]  bx1_ff, by1_ff, cx1_ff, cy1_ff;
   logic signed [DiffW-1:0]  bx2_ff, by2_ff, cx2_ff, cy2_ff;
   logic signed [DiffW-1:0]  bx3_ff, by3_ff, cx3_ff, cy3_ff;
   logic signed [SqW-1:0]    bxbx_ff, byby_ff, cxcx_ff, cycy_ff, bxcy_ff, bycx_ff;
   logic signed [SumW-1:0]   bb_ff, cc_ff;
   logic signed [DenW-1:0]   d3_ff, d4_ff;
   logic signed [NumW-1:0]   cybb_ff, bycc_ff, bxcc_ff, cxbb_ff;
   logic signed [NumW-1:0]   nx_in, ny_in;
   logic [NumW-1:0]          nx_mag_ff, ny_mag_ff;
   logic [DenW-1:0]          den_mag_ff;
   logic                     neg_x_ff, neg_y_ff, degen_ff;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff; v5_ff <= v4_ff;
      end
   end

   assign nx_in = cybb_ff - bycc_ff;
   assign ny_in = bxcc_ff - cxbb_ff;

   // stage 1: edges from vertex one; 2: products; 3: squared lengths and d;
   // 4: numerator products; 5: numerators and magnitudes
   always_ff @(posedge clock) begin
      if (en) begin
         x1_1_ff <= p1_x; y1_1_ff <= p1_y;
         bx1_ff  <= DiffW'(p2_x) - DiffW'(p1_x);
         by1_ff  <= DiffW'(p2_y) - DiffW'(p1_y);
         cx1_ff  <= DiffW'(p3_x) - DiffW'(p1_x);
         cy1_ff  <= DiffW'(p3_y) - DiffW'(p1_y);

         x1_2_ff <= x1_1_ff; y1_2_ff <= y1_1_ff;
         bx2_ff <= bx1_ff; by2_ff <= by1_ff; cx2_ff <= cx1_ff; cy2_ff <= cy1_ff;
         bxbx_ff <= SqW'(bx1_ff) * SqW'(bx1_ff);
         byby_ff <= SqW'(by1_ff) * SqW'(by1_ff);
         cxcx_ff <= SqW'(cx1_ff) * SqW'(cx1_ff);
         cycy_ff <= SqW'(cy1_ff) * SqW'(cy1_ff);
         bxcy_ff <= SqW'(bx1_ff) * SqW'(cy1_ff);
         bycx_ff <= SqW'(by1_ff) * SqW'(cx1_ff);

         x1_3_ff <= x1_2_ff; y1_3_ff <= y1_2_ff;
         bx3_ff <= bx2_ff; by3_ff <= by2_ff; cx3_ff <= cx2_ff; cy3_ff <= cy2_ff;
         bb_ff <= SumW'(bxbx_ff) + SumW'(byby_ff);
         cc_ff <= SumW'(cxcx_ff) + SumW'(cycy_ff);
         d3_ff <= (DenW'(bxcy_ff) - DenW'(bycx_ff)) <<< 1;

         x1_4_ff <= x1_3_ff; y1_4_ff <= y1_3_ff;
         d4_ff   <= d3_ff;
         cybb_ff <= NumW'(cy3_ff) * NumW'(bb_ff);
         bycc_ff <= NumW'(by3_ff) * NumW'(cc_ff);
         bxcc_ff <= NumW'(bx3_ff) * NumW'(cc_ff);
         cxbb_ff <= NumW'(cx3_ff) * NumW'(bb_ff);

         x1_5_ff    <= x1_4_ff; y1_5_ff <= y1_4_ff;
         nx_mag_ff  <= nx_in[NumW-1] ? -nx_in : nx_in;
         ny_mag_ff  <= ny_in[NumW-1] ? -ny_in : ny_in;
         den_mag_ff <= d4_ff[DenW-1] ? -d4_ff : d4_ff;
         neg_x_ff   <= nx_in[NumW-1] ^ d4_ff[DenW-1];
         neg_y_ff   <= ny_in[NumW-1] ^ d4_ff[DenW-1];
         degen_ff   <= (d4_ff == '0);
      end
   end

   assign out_valid = v5_ff;
   assign nx_mag    = nx_mag_ff;
   assign ny_mag    = ny_mag_ff;
   assign den_mag   = den_mag_ff;
   assign neg_x     = neg_x_ff;
   assign neg_y     = neg_y_ff;
   assign x1        = x1_5_ff;
   assign y1        = y1_5_ff;
   assign degen     = degen_ff;

endmodule

// ----- src/ccu_div.sv -----
module ccu_div #(
   parameter int SIDE_W = 33
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [ccu_pkg::NumW-1:0]   in_nx,
   input  logic [ccu_pkg::NumW-1:0]   in_ny,
   input  logic [ccu_pkg::DenW-1:0]   in_den,
   input  logic                       in_neg_x,
   input  logic                       in_neg_y,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_valid,
   output ccu_pkg::lane_res_type      out_x,
   output ccu_pkg::lane_res_type      out_y,
   output logic [SIDE_W-1:0]          out_side
);
   import ccu_pkg::*;

   localparam int ExtW = DenW + QBits;

   logic              v_ff    [0:QBits];
   logic [NumW-1:0]   rx_ff   [0:QBits];
   logic [NumW-1:0]   ry_ff   [0:QBits];
   logic [QBits-1:0]  qx_ff   [0:QBits];
   logic [QBits-1:0]  qy_ff   [0:QBits];
   logic [DenW-1:0]   den_ff  [0:QBits];
   logic              ox_ff   [0:QBits];
   logic              oy_ff   [0:QBits];
   logic              nx_ff   [0:QBits];
   logic              ny_ff   [0:QBits];
   logic [SIDE_W-1:0] side_ff [0:QBits];

   // entry stage: quotient of 2^QBits or more is flagged as overflow
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff[0]   <= in_nx;
         ry_ff[0]   <= in_ny;
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         den_ff[0]  <= in_den;
         ox_ff[0]   <= ExtW'(in_nx) >= (ExtW'(in_den) << QBits);
         oy_ff[0]   <= ExtW'(in_ny) >= (ExtW'(in_den) << QBits);
         nx_ff[0]   <= in_neg_x;
         ny_ff[0]   <= in_neg_y;
         side_ff[0] <= in_side;
      end
   end

   // one restoring step per stage, most significant quotient bit first
   for (genvar k = 1; k <= QBits; k++) begin : g_step
      localparam int Bit = QBits - k;
      logic [ExtW-1:0] trial;
      logic            take_x, take_y;

      assign trial  = ExtW'(den_ff[k-1]) << Bit;
      assign take_x = ExtW'(rx_ff[k-1]) >= trial;
      assign take_y = ExtW'(ry_ff[k-1]) >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rx_ff[k]   <= take_x ? rx_ff[k-1] - trial[NumW-1:0] : rx_ff[k-1];
            ry_ff[k]   <= take_y ? ry_ff[k-1] - trial[NumW-1:0] : ry_ff[k-1];
            qx_ff[k]   <= qx_ff[k-1] | (QBits'(take_x) << Bit);
            qy_ff[k]   <= qy_ff[k-1] | (QBits'(take_y) << Bit);
            den_ff[k]  <= den_ff[k-1];
            ox_ff[k]   <= ox_ff[k-1];
            oy_ff[k]   <= oy_ff[k-1];
            nx_ff[k]   <= nx_ff[k-1];
            ny_ff[k]   <= ny_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid     = v_ff[QBits];
   assign out_x.ovf     = ox_ff[QBits];
   assign out_x.neg     = nx_ff[QBits];
   assign out_x.rem_nz  = (rx_ff[QBits] != '0);
   assign out_x.q       = qx_ff[QBits];
   assign out_y.ovf     = oy_ff[QBits];
   assign out_y.neg     = ny_ff[QBits];
   assign out_y.rem_nz  = (ry_ff[QBits] != '0);
   assign out_y.q       = qy_ff[QBits];
   assign out_side      = side_ff[QBits];

endmodule

// ----- src/ccu_sqrt.sv -----
module ccu_sqrt #(
   parameter int SIDE_W = 50
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [ccu_pkg::RadW-1:0]      in_rad,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [ccu_pkg::RootBits-1:0]  out_root,
   output logic [SIDE_W-1:0]             out_side
);
   import ccu_pkg::*;

   logic                v_ff    [0:RootBits];
   logic [RadW-1:0]     rem_ff  [0:RootBits];
   logic [RootBits-1:0] root_ff [0:RootBits];
   logic [SIDE_W-1:0]   side_ff [0:RootBits];

   // entry stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= in_rad;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   // one root bit per stage: trial = (2*root + 2^i) * 2^i
   for (genvar k = 1; k <= RootBits; k++) begin : g_step
      localparam int Bit = RootBits - k;
      logic [RadW-1:0] trial;
      logic            take;

      assign trial = (RadW'(root_ff[k-1]) << (Bit + 1)) | (RadW'(1) << (2 * Bit));
      assign take  = rem_ff[k-1] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? rem_ff[k-1] - trial : rem_ff[k-1];
            root_ff[k] <= root_ff[k-1] | (RootBits'(take) << Bit);
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[RootBits];
   assign out_root  = root_ff[RootBits];
   assign out_side  = side_ff[RootBits];

endmodule

// ----- src/triangle_circumcircle_unit.sv -----
// Pipeline from an accepted req beat to its rsp beat: 5 front stages, 26 divider
// stages, 2 post stages, 26 square-root stages, output register. Throughput: one
// triangle per cycle unless stalled; the divider and square root are fully pipelined.
// Backpressure stalls every stage at once; req_tready is high whenever the output
// register is empty or being taken. Synchronous active-high reset clears valid bits.
module triangle_circumcircle_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (16 bits each)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // center_x, center_y, radius (24 bits each)
   output logic        rsp_tuser   // degenerate
);
   import ccu_pkg::*;

   localparam int DivSideW  = 2 * CoordW + 1;
   localparam int SqrtSideW = 2 * OutW + 2;

   logic                     en;
   logic                     f_valid, f_neg_x, f_neg_y, f_degen;
   logic [NumW-1:0]          f_nx, f_ny;
   logic [DenW-1:0]          f_den;
   logic signed [CoordW-1:0] f_x1, f_y1;
   logic                     d_valid;
   lane_res_type             d_x, d_y;
   logic [DivSideW-1:0]      d_side;
   logic signed [CoordW-1:0] d_x1, d_y1;
   logic                     d_degen;

   logic                     p1_v_ff, p2_v_ff;
   logic signed [QW-1:0]     ux_in, uy_in, ux_ff, uy_ff;
   logic signed [QW:0]       sx_in, sy_in;
   logic signed [OutW-1:0]   cx_in, cy_in, cx1_ff, cy1_ff, cx2_ff, cy2_ff;
   logic                     big_in, big1_ff, big2_ff, dg1_ff, dg2_ff;
   logic signed [2*QW-1:0]   sqx_ff, sqy_ff;
   logic [RadW-1:0]          rad_sum;

   logic                     s_valid;
   logic [RootBits-1:0]      s_root;
   logic [SqrtSideW-1:0]     s_side;
   logic signed [OutW-1:0]   s_cx, s_cy;
   logic                     s_big, s_degen;

   logic                     rsp_valid_ff;
   logic [OutW-1:0]          cx_o_ff, cy_o_ff, rad_o_ff;
   logic                     dg_o_ff;
   logic [OutW-1:0]          rad_in;

   // whole pipeline moves when the output register can take a beat
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   ccu_front u_front (
      .clock, .reset, .en,
      .in_valid (req_tvalid && en),
      .p1_x     (req_tdata[15:0]),
      .p1_y     (req_tdata[31:16]),
      .p2_x     (req_tdata[47:32]),
      .p2_y     (req_tdata[63:48]),
      .p3_x     (req_tdata[79:64]),
      .p3_y     (req_tdata[95:80]),
      .out_valid(f_valid),
      .nx_mag   (f_nx),
      .ny_mag   (f_ny),
      .den_mag  (f_den),
      .neg_x    (f_neg_x),
      .neg_y    (f_neg_y),
      .x1       (f_x1),
      .y1       (f_y1),
      .degen    (f_degen)
   );

   ccu_div #(.SIDE_W(DivSideW)) u_div (
      .clock, .reset, .en,
      .in_valid (f_valid),
      .in_nx    (f_nx),
      .in_ny    (f_ny),
      .in_den   (f_den),
      .in_neg_x (f_neg_x),
      .in_neg_y (f_neg_y),
      .in_side  ({f_degen, f_y1, f_x1}),
      .out_valid(d_valid),
      .out_x    (d_x),
      .out_y    (d_y),
      .out_side (d_side)
   );

   assign d_x1    = d_side[CoordW-1:0];
   assign d_y1    = d_side[2*CoordW-1:CoordW];
   assign d_degen = d_side[DivSideW-1];

   // floor correction, centre with saturation, overflow test for the radius
   function automatic logic signed [QW-1:0] floor_q(lane_res_type r);
      logic signed [QW-1:0] m;
      m = QW'(r.q) + QW'(r.rem_nz);
      return r.neg ? -m : QW'(r.q);
   endfunction

   function automatic logic signed [OutW-1:0] sat_c(logic signed [QW:0] s,
                                                    lane_res_type r);
      logic signed [QW:0] hi, lo;
      hi = (QW+1)'(CenMax);
      lo = (QW+1)'(CenMin);
      if (r.ovf) begin
         return r.neg ? CenMin : CenMax;
      end else if (s > hi) begin
         return CenMax;
      end else if (s < lo) begin
         return CenMin;
      end
      return s[OutW-1:0];
   endfunction

   function automatic logic too_big(logic signed [QW-1:0] u, lane_res_type r);
      logic signed [QW-1:0] lim;
      lim = QW'(1) <<< OutW;
      return r.ovf || (u >= lim) || (u <= -lim);
   endfunction

   assign ux_in  = floor_q(d_x);
   assign uy_in  = floor_q(d_y);
   assign sx_in  = (QW+1)'(d_x1) + (QW+1)'(ux_in);
   assign sy_in  = (QW+1)'(d_y1) + (QW+1)'(uy_in);
   assign cx_in  = sat_c(sx_in, d_x);
   assign cy_in  = sat_c(sy_in, d_y);
   assign big_in = too_big(ux_in, d_x) || too_big(uy_in, d_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
      end else if (en) begin
         p1_v_ff <= d_valid;
         p2_v_ff <= p1_v_ff;
      end
   end

   // post stages: centre, then squares of the offsets
   always_ff @(posedge clock) begin
      if (en) begin
         ux_ff   <= ux_in;
         uy_ff   <= uy_in;
         cx1_ff  <= cx_in;
         cy1_ff  <= cy_in;
         big1_ff <= big_in;
         dg1_ff  <= d_degen;

         sqx_ff  <= (2*QW)'(ux_ff) * (2*QW)'(ux_ff);
         sqy_ff  <= (2*QW)'(uy_ff) * (2*QW)'(uy_ff);
         cx2_ff  <= cx1_ff;
         cy2_ff  <= cy1_ff;
         big2_ff <= big1_ff;
         dg2_ff  <= dg1_ff;
      end
   end

   assign rad_sum = sqx_ff[RadW-1:0] + sqy_ff[RadW-1:0];

   ccu_sqrt #(.SIDE_W(SqrtSideW)) u_sqrt (
      .clock, .reset, .en,
      .in_valid (p2_v_ff),
      .in_rad   (rad_sum),
      .in_side  ({dg2_ff, big2_ff, cy2_ff, cx2_ff}),
      .out_valid(s_valid),
      .out_root (s_root),
      .out_side (s_side)
   );

   assign s_cx    = s_side[OutW-1:0];
   assign s_cy    = s_side[2*OutW-1:OutW];
   assign s_big   = s_side[2*OutW];
   assign s_degen = s_side[2*OutW+1];
   assign rad_in  = (s_big || s_root[RootBits-1]) ? RadMax : s_root[OutW-1:0];

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_o_ff  <= s_degen ? '0 : s_cx;
         cy_o_ff  <= s_degen ? '0 : s_cy;
         rad_o_ff <= s_degen ? '0 : rad_in;
         dg_o_ff  <= s_degen;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rad_o_ff, cy_o_ff, cx_o_ff};
   assign rsp_tuser  = dg_o_ff;

endmodule

// ----- sim/triangle_circumcircle_unit_tb.sv -----
`timescale 1ns / 1ps

module triangle_circumcircle_unit_tb;

   // result of one triangle
   typedef struct {
      logic [23:0] cx;
      logic [23:0] cy;
      logic [23:0] rad;
      logic        degen;
   } circle_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;

   circle_type circle_q[$];
   int      n_fail;
   int      n_rsp;
   int      n_degen;
   int      n_sat;
   bit      quiet;

   triangle_circumcircle_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // floor division, quotient rounded towards minus infinity
   function automatic longint floor_quot(longint n, longint d);
      longint q;
      longint r;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      q = n / d;
      r = n % d;
      if (r != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint clamp_centre(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic longint unsigned int_root(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // circumcircle taken relative to vertex one, exact in integers
   function automatic circle_type circumcircle(logic [95:0] tri_v);
      circle_type     c;
      longint         x1, y1, bx, by, cx, cy, bb, cc, d, ux, uy;
      longint unsigned r;
      x1 = longint'($signed(tri_v[15:0]));
      y1 = longint'($signed(tri_v[31:16]));
      bx = longint'($signed(tri_v[47:32])) - x1;
      by = longint'($signed(tri_v[63:48])) - y1;
      cx = longint'($signed(tri_v[79:64])) - x1;
      cy = longint'($signed(tri_v[95:80])) - y1;
      bb = bx * bx + by * by;
      cc = cx * cx + cy * cy;
      d = 2 * (bx * cy - by * cx);
      if (d == 0) begin
         c.cx = '0; c.cy = '0; c.rad = '0; c.degen = 1'b1;
         return c;
      end
      ux = floor_quot(cy * bb - by * cc, d);
      uy = floor_quot(bx * cc - cx * bb, d);
      if (ux >= (64'sd1 << 24) || ux <= -(64'sd1 << 24) ||
          uy >= (64'sd1 << 24) || uy <= -(64'sd1 << 24)) begin
         r = 64'd16777215;
      end else begin
         r = int_root(longint'(ux * ux) + longint'(uy * uy));
         if (r > 64'd16777215) r = 64'd16777215;
      end
      c.cx = 24'(clamp_centre(x1 + ux));
      c.cy = 24'(clamp_centre(y1 + uy));
      c.rad = r[23:0];
      c.degen = 1'b0;
      return c;
   endfunction

   function automatic logic [95:0] pack_tri(int ax, int ay, int bx, int by, int cx, int cy);
      return {cy[15:0], cx[15:0], by[15:0], bx[15:0], ay[15:0], ax[15:0]};
   endfunction

   // one request beat; valid held high between back-to-back beats
   task automatic send_tri(logic [95:0] t);
      if (!quiet && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      circle_q.push_back(circumcircle(t));
      @(negedge clock);
   endtask

   // random vertex coordinate: full range, small ranges and extremes
   function automatic int rnd_coord();
      case ($urandom_range(7))
         0: return $urandom_range(1) ? 32767 : -32768;
         1, 2: return int'($urandom_range(511)) - 256;
         default: return int'($signed(16'($urandom())));
      endcase
   endfunction

   // directed table: extremes, degenerate shapes, saturation
   localparam int NDIR = 12;
   logic [95:0] dir_tri[NDIR];
   bit          dir_known[NDIR];
   circle_type  dir_res[NDIR];

   initial begin
      logic [95:0] t;
      int ax, ay, k;
      circle_type deg;
      deg.cx = '0; deg.cy = '0; deg.rad = '0; deg.degen = 1'b1;
      dir_tri[0]  = '0;                                        // coincident at origin
      dir_tri[1]  = pack_tri(5, 5, 5, 5, 5, 5);                // coincident
      dir_tri[2]  = pack_tri(0, 0, 256, 256, 512, 512);        // collinear
      dir_tri[3]  = pack_tri(-32768, -32768, 32767, 32767, 32767, 32767);
      dir_tri[4]  = pack_tri(0, 0, 256, 0, 0, 256);
      dir_tri[5]  = pack_tri(-32768, -32768, 32767, -32768, -32768, 32767);
      dir_tri[6]  = pack_tri(32767, 32767, -32768, 32767, 32767, -32768);
      dir_tri[7]  = pack_tri(0, 0, 32767, 0, -32768, 1);       // near-collinear, saturates
      dir_tri[8]  = pack_tri(-32768, 0, 32767, 0, 0, 1);
      dir_tri[9]  = pack_tri(0, -32768, 0, 32767, 1, 0);
      dir_tri[10] = pack_tri(-1, -1, 1, -1, -1, 1);
      dir_tri[11] = pack_tri(32767, -32768, -32768, 32767, 0, 0);
      for (int i = 0; i < NDIR; i++) dir_known[i] = (i < 3);
      for (int i = 0; i < 3; i++) dir_res[i] = deg;

      n_fail = 0; n_rsp = 0; n_degen = 0; n_sat = 0; quiet = 0;
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0; rsp_tready = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, hand results where obvious
      for (int i = 0; i < NDIR; i++) begin
         send_tri(dir_tri[i]);
         if (dir_known[i]) circle_q[$] = dir_res[i];
      end

      // random triangles
      for (int i = 0; i < 1750; i++) begin
         quiet = (i >= 600 && i < 900);
         if (i == 1000) begin
            // hold off until the pipe has drained
            req_tvalid <= 1'b0;
            while (circle_q.size() != 0) @(negedge clock);
         end
         k = $urandom_range(9);
         if (k == 0) begin
            // collinear: third vertex on the line through the first two
            ax = rnd_coord(); ay = rnd_coord();
            t = pack_tri(ax, ay, ax + 3, ay + 7, ax + 9, ay + 21);
         end else if (k == 1) begin
            ax = rnd_coord(); ay = rnd_coord();
            t = pack_tri(ax, ay, ax, ay, rnd_coord(), rnd_coord());
         end else begin
            t = pack_tri(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                         rnd_coord(), rnd_coord());
         end
         send_tri(t);
      end
      req_tvalid <= 1'b0;

      while (circle_q.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      $display("covered %0d responses, %0d degenerate, %0d with saturated radius",
               n_rsp, n_degen, n_sat);
      $display("directed extremes, coincident/collinear triangles, random stalls and a drain");
      if (n_fail == 0 && circle_q.size() == 0) begin
         $display("[triangle_circumcircle_unit] OK");
      end else begin
         $display("[triangle_circumcircle_unit] ERROR");
      end
      $finish;
   end

   // receiver stalls
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 6);
   end

   // compare each response beat with the oldest expected circle
   always @(posedge clock) begin
      circle_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_rsp++;
         if (circle_q.size() == 0) begin
            n_fail++;
            $display("%0t: unexpected beat %h/%b", $time, rsp_tdata, rsp_tuser);
         end else begin
            e = circle_q.pop_front();
            if (e.degen) n_degen++;
            if (e.rad == 24'hFFFFFF) n_sat++;
            if (rsp_tdata[23:0] !== e.cx) begin
               n_fail++;
               $display("%0t: center_x exp %h got %h", $time, e.cx, rsp_tdata[23:0]);
            end
            if (rsp_tdata[47:24] !== e.cy) begin
               n_fail++;
               $display("%0t: center_y exp %h got %h", $time, e.cy, rsp_tdata[47:24]);
            end
            if (rsp_tdata[71:48] !== e.rad) begin
               n_fail++;
               $display("%0t: radius exp %h got %h", $time, e.rad, rsp_tdata[71:48]);
            end
            if (rsp_tuser !== e.degen) begin
               n_fail++;
               $display("%0t: degenerate exp %b got %b", $time, e.degen, rsp_tuser);
            end
         end
      end
   end

   // watchdog
   initial begin
      #400000;
      $display("[triangle_circumcircle_unit] ERROR");
      $finish;
   end

endmodule
